>>> rtl/sha256_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sha256_pkg;

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [3:0] LenWord = 4'd14;  // first word of the length field

  typedef enum logic [2:0] {
    ST_IDLE, ST_PAD, ST_ROUND, ST_FOLD, ST_OUT
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic       wr_byte;    // write data byte at fill position
    logic       wr_pad;     // pad byte then zero to end of word
    logic       zero_word;  // clear schedule word at pad_idx
    logic       len_word;   // write length words at pad_idx and pad_idx+1
    logic [3:0] pad_idx;
    logic       start;      // load working vars
    logic       round;      // one round step
    logic       fold;       // add into hash words
    logic       clear;      // back to initial hash, count zero
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [5:0] fill;
  } dp_stat_t;

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

>>> rtl/sha256_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface sha256_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] data_byte;
  modport source (output valid, func, data_byte, input ready);
  modport sink (input valid, func, data_byte, output ready);
endinterface

interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

>>> rtl/sha256_stream_hasher_unit.sv
// SHA-256 over a byte stream.
// Input channel in_if: func=0 absorbs data_byte, func=1 finishes the message.
// Output channel out_if: eight digest words, word_index 0..7, last_word on 7.
// Absorbs are taken while idle; the 64th byte of a block starts a compression
// of 64 rounds and a fold step, one round per cycle through a single
// round unit, during which input is held off.
// Finish writes the pad byte, clears remaining schedule words one a cycle,
// writes the length, compresses (twice if more than 55 bytes were buffered),
// then presents the digest words one per cycle while out_if.ready is high.
// The first digest word is presented once the fold of the final block is done.
// A stalled receiver holds the current word; no input is taken until the
// eighth word is taken, after which hash, count and length are reinitialized.
// Reset (rst_ni low, async) restores the initial hash values and empties
// the buffer; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module sha256_stream_hasher_unit (
  input wire             clk_i,
  input wire             rst_ni,
  sha256_in_if.sink      in_if,
  sha256_out_if.source   out_if
);
  import sha256_pkg::*;

  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic [2:0]  idx;
  logic        ready;

  sha256_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_if.valid),
    .in_ready_o (ready),
    .in_func_i  (in_if.func),
    .out_valid_o(out_if.valid),
    .out_ready_i(out_if.ready),
    .out_idx_o  (idx),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  sha256_dp u_dp (
    .clk_i, .rst_ni,
    .cmd_i   (cmd),
    .byte_i  (in_if.data_byte),
    .rd_idx_i(idx),
    .stat_o  (stat),
    .hash_o  (out_if.digest_word)
  );

  assign in_if.ready       = ready;
  assign out_if.word_index = idx;
  assign out_if.last_word  = (idx == 3'd7);
endmodule
`default_nettype wire

>>> rtl/sha256_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module sha256_dp (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  sha256_pkg::dp_cmd_t  cmd_i,
  input  wire [7:0]            byte_i,
  input  wire [2:0]            rd_idx_i,
  output sha256_pkg::dp_stat_t stat_o,
  output logic [31:0]          hash_o
);
  import sha256_pkg::*;

  // sixteen-word sliding schedule window, working vars, hash words
  logic [31:0] w_q [16];
  logic [31:0] v_q [8];
  logic [31:0] h_q [8];
  logic [5:0]  fill_q;
  logic [63:0] bits_q;
  logic [5:0]  rnd_q;

  logic [31:0] s0, s1, wnew, t1, t2, big0, big1, chv, majv;
  logic [3:0]  widx;
  logic [1:0]  bsel;
  logic [31:0] mask;

  assign stat_o.fill = fill_q;
  assign hash_o = h_q[rd_idx_i];
  assign widx = fill_q[5:2];
  assign bsel = fill_q[1:0];

  // round logic
  always_comb begin
    s0 = ror(w_q[1], 7) ^ ror(w_q[1], 18) ^ (w_q[1] >> 3);
    s1 = ror(w_q[14], 17) ^ ror(w_q[14], 19) ^ (w_q[14] >> 10);
    wnew = w_q[0] + s0 + w_q[9] + s1;
    big1 = ror(v_q[4], 6) ^ ror(v_q[4], 11) ^ ror(v_q[4], 25);
    chv = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t1 = v_q[7] + big1 + chv + RoundK[rnd_q] + w_q[0];
    big0 = ror(v_q[0], 2) ^ ror(v_q[0], 13) ^ ror(v_q[0], 22);
    majv = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t2 = big0 + majv;
    mask = 32'hffffffff >> {bsel, 3'b000};
  end

  // schedule window and byte loads
  always_ff @(posedge clk_i) begin
    if (cmd_i.round) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
      w_q[15] <= wnew;
    end else if (cmd_i.wr_byte) begin
      w_q[widx] <= (w_q[widx] & ~mask) | ((32'(byte_i) << {~bsel, 3'b000}) & mask);
    end else if (cmd_i.wr_pad) begin
      w_q[widx] <= (w_q[widx] & ~mask) | ((32'(PadByte) << {~bsel, 3'b000}) & mask);
    end else if (cmd_i.zero_word) begin
      w_q[cmd_i.pad_idx] <= '0;
    end else if (cmd_i.len_word) begin
      w_q[cmd_i.pad_idx] <= bits_q[63:32];
      w_q[cmd_i.pad_idx + 4'd1] <= bits_q[31:0];
    end
  end

  // working vars
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
    end else if (cmd_i.round) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  // control-side state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) h_q[i] <= InitHash[i];
      fill_q <= '0;
      bits_q <= '0;
      rnd_q  <= '0;
    end else begin
      if (cmd_i.start) rnd_q <= '0;
      else if (cmd_i.round) rnd_q <= rnd_q + 6'd1;
      if (cmd_i.clear) begin
        for (int i = 0; i < 8; i++) h_q[i] <= InitHash[i];
        fill_q <= '0;
        bits_q <= '0;
      end else begin
        if (cmd_i.fold) begin
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
        end
        if (cmd_i.wr_byte) begin
          fill_q <= fill_q + 6'd1;
          bits_q <= bits_q + 64'd8;
        end
      end
    end
  end
endmodule
`default_nettype wire

>>> rtl/sha256_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module sha256_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  wire                  in_func_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output logic [2:0]           out_idx_o,
  output sha256_pkg::dp_cmd_t  cmd_o,
  input  sha256_pkg::dp_stat_t stat_i
);
  import sha256_pkg::*;

  ctrl_state_e state_q, state_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        fin_q, fin_d;     // finishing
  logic        final_q, final_d; // this block carries the length
  logic        acc;

  assign acc = in_valid_i && in_ready_o;

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    fin_d   = fin_q;
    final_d = final_q;
    unique case (state_q)
      ST_IDLE: begin
        if (acc) begin
          if (in_func_i) begin
            state_d = ST_PAD;
            fin_d   = 1'b1;
            // pad word index after the 0x80 word
            cnt_d   = {2'b00, stat_i.fill[5:2]} + 6'd1;
            final_d = (stat_i.fill < 6'd56);
          end else if (stat_i.fill == 6'd63) begin
            state_d = ST_ROUND;
            cnt_d   = '0;
            fin_d   = 1'b0;
          end
        end
      end
      ST_PAD: begin
        // zero words up to the length, or to block end
        if (final_q && cnt_q[3:0] >= LenWord) begin
          state_d = ST_ROUND;
          cnt_d   = '0;
        end else if (!final_q && cnt_q == 6'd16) begin
          state_d = ST_ROUND;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      ST_ROUND: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd63) state_d = ST_FOLD;
      end
      ST_FOLD: begin
        cnt_d = '0;
        if (!fin_q) state_d = ST_IDLE;
        else if (final_q) state_d = ST_OUT;
        else begin
          state_d = ST_PAD;
          final_d = 1'b1;
        end
      end
      ST_OUT: begin
        if (out_ready_i) begin
          cnt_d = cnt_q + 6'd1;
          if (cnt_q == 6'd7) begin
            state_d = ST_IDLE;
            fin_d   = 1'b0;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    out_idx_o   = cnt_q[2:0];
    cmd_o.pad_idx = cnt_q[3:0];
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.wr_byte = acc && !in_func_i;
        cmd_o.wr_pad  = acc && in_func_i;
        cmd_o.start   = acc && (in_func_i ? 1'b0 : stat_i.fill == 6'd63);
      end
      ST_PAD: begin
        if (final_q && cnt_q[3:0] >= LenWord) begin
          cmd_o.len_word = 1'b1;
          cmd_o.pad_idx  = LenWord;
          cmd_o.start    = 1'b1;
        end else if (!final_q && cnt_q == 6'd16) begin
          cmd_o.start = 1'b1;
        end else begin
          cmd_o.zero_word = 1'b1;
        end
      end
      ST_ROUND: cmd_o.round = 1'b1;
      ST_FOLD:  cmd_o.fold = 1'b1;
      ST_OUT: begin
        out_valid_o = 1'b1;
        cmd_o.clear = out_ready_i && cnt_q == 6'd7;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      fin_q   <= 1'b0;
      final_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      fin_q   <= fin_d;
      final_q <= final_d;
    end
  end
endmodule
`default_nettype wire

>>> rtl/sha256_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module sha256_checker (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       in_valid,
  input wire       in_ready,
  input wire       out_valid,
  input wire       out_ready,
  input wire [2:0] word_index,
  input wire       last_word
);
  // no input taken while digest words are pending
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !(in_valid && in_ready)) else $error("input taken during output");
  // last flag marks index seven
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (last_word == (word_index == 3'd7))) else $error("last flag");
  // words advance by one
  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready && !last_word |=> out_valid && word_index == $past(word_index) + 3'd1)
    else $error("index step");
  // words stall in place
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(word_index)) else $error("hold");
endmodule

bind sha256_stream_hasher_unit sha256_checker u_chk (
  .clk_i, .rst_ni,
  .in_valid(in_if.valid), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready),
  .word_index(out_if.word_index), .last_word(out_if.last_word)
);
`default_nettype wire

>>> verif/sha256_stream_hasher_unit_tb.sv
`timescale 1ns / 1ps
module sha256_stream_hasher_unit_tb;
  import sha256_pkg::*;

  localparam int unsigned StallLimit = 20000;
  localparam logic FuncAbsorb = 1'b0;
  localparam logic FuncFinish = 1'b1;

  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
  } byte_word_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_word_t;

  logic clk_i;
  logic rst_ni;

  sha256_in_if  in_if ();
  sha256_out_if out_if ();

  sha256_stream_hasher_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .out_if (out_if.source)
  );

  // hasher state mirror
  logic [31:0] hash_q [8];
  logic [7:0]  blk_q [64];
  int unsigned fill_q;
  logic [63:0] bits_q;

  byte_word_t   pending_q [$];
  digest_word_t digest_q [$];
  int unsigned  err_cnt = 0;
  int unsigned  src_idle_pct, snk_idle_pct;
  bit           hold_on;
  event         hold_ev;
  int unsigned  quiet_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [31:0] rotr(logic [31:0] x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress_blk();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++) begin
      w[i] = {blk_q[4*i], blk_q[4*i+1], blk_q[4*i+2], blk_q[4*i+3]};
    end
    for (int i = 16; i < 64; i++) begin
      w[i] = w[i-16] + w[i-7]
           + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
           + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
    end
    for (int i = 0; i < 8; i++) v[i] = hash_q[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[i] + w[i];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_q[i] += v[i];
  endtask

  task automatic clear_hash();
    for (int i = 0; i < 8; i++) hash_q[i] = InitHash[i];
    fill_q = 0;
    bits_q = '0;
  endtask

  // absorb one byte, or pad and queue the eight digest words
  task automatic hash_word(byte_word_t w);
    digest_word_t d;
    if (w.func == FuncAbsorb) begin
      blk_q[fill_q] = w.data_byte;
      bits_q += 64'd8;
      fill_q++;
      if (fill_q == 64) begin
        compress_blk();
        fill_q = 0;
      end
    end else begin
      blk_q[fill_q] = PadByte;
      fill_q++;
      if (fill_q > 56) begin
        for (int i = fill_q; i < 64; i++) blk_q[i] = 8'h00;
        compress_blk();
        fill_q = 0;
      end
      for (int i = fill_q; i < 56; i++) blk_q[i] = 8'h00;
      for (int i = 0; i < 8; i++) blk_q[56+i] = bits_q[63-8*i -: 8];
      compress_blk();
      for (int i = 0; i < 8; i++) begin
        d.digest_word = hash_q[i];
        d.word_index  = 3'(i);
        d.last_word   = (i == 7);
        digest_q.insert(digest_q.size(), d);
      end
      clear_hash();
    end
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch %s: got %h expected %h", $realtime, what, got, want);
    err_cnt++;
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.func <= 1'b0;
      in_if.data_byte <= 8'h00;
      clear_hash();
    end else begin
      if (in_if.valid && in_if.ready) hash_word('{in_if.func, in_if.data_byte});
      if (!(in_if.valid && !in_if.ready)) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          in_if.valid <= 1'b1;
          {in_if.func, in_if.data_byte} <= pending_q.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted here
  always begin
    @(hold_ev);
    hold_on <= 1'b1;
    repeat (400) @(posedge clk_i);
    hold_on <= 1'b0;
  end

  // monitor and receiver
  always @(posedge clk_i or negedge rst_ni) begin
    digest_word_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (digest_q.size() == 0) begin
          report_mismatch("unexpected digest_word", out_if.digest_word, '0);
        end else begin
          want = digest_q.pop_front();
          if (out_if.digest_word !== want.digest_word)
            report_mismatch("digest_word", out_if.digest_word, want.digest_word);
          if (out_if.word_index !== want.word_index)
            report_mismatch("word_index", 32'(out_if.word_index), 32'(want.word_index));
          if (out_if.last_word !== want.last_word)
            report_mismatch("last_word", 32'(out_if.last_word), 32'(want.last_word));
        end
      end
      if (hold_on) begin
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // watchdog on accept activity
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("sha256_stream_hasher_unit verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic add_msg(int unsigned len, bit fixed, logic [7:0] val);
    for (int i = 0; i < len; i++)
      pending_q.insert(pending_q.size(),
                       '{FuncAbsorb, fixed ? val : 8'($urandom_range(255))});
    pending_q.insert(pending_q.size(), '{FuncFinish, 8'($urandom_range(255))});
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0 || in_if.valid || digest_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned len;
    rst_ni = 1'b0;
    src_idle_pct = 0;
    snk_idle_pct = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty message, single bytes at extremes, short messages
    add_msg(0, 1'b1, 8'h00);
    add_msg(1, 1'b1, 8'h00);
    add_msg(1, 1'b1, 8'hff);
    add_msg(3, 1'b0, 8'h00);
    add_msg(2, 1'b1, 8'h55);
    add_msg(2, 1'b1, 8'haa);
    add_msg(1, 1'b1, 8'h80);
    add_msg(0, 1'b1, 8'h00);
    wait_drained();

    // three phases (source/sink idling in the first two), lengths around the 55/56 and 64 boundaries
    for (int phase = 0; phase < 3; phase++) begin
      src_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 46 : 0;
      snk_idle_pct = (phase == 0) ? 46 : (phase == 1) ? 18 : 0;
      add_msg((phase == 0) ? 55 : (phase == 1) ? 56 : 63, 1'b0, 8'h00);
      if (phase == 2) add_msg(64, 1'b0, 8'h00);
      for (int m = 0; m < 2; m++) begin
        len = $urandom_range(12);
        add_msg(len, 1'b0, 8'h00);
      end
      // long receiver stall while input keeps coming
      if (phase == 0) begin
        add_msg(2, 1'b0, 8'h00);
        add_msg(5, 1'b0, 8'h00);
        -> hold_ev;
      end
      wait_drained();
      // sender pause until all digests are out
      add_msg($urandom_range(4), 1'b0, 8'h00);
      wait_drained();
    end

    repeat (200) @(posedge clk_i);
    if (err_cnt == 0 && digest_q.size() == 0) begin
      $display("sha256_stream_hasher_unit verification clean");
    end else begin
      $display("sha256_stream_hasher_unit verification failed");
    end
    $finish;
  end

endmodule
